// ===== hw/rtl/mac_learning_forward_table_assert.svh =====
// Assertion macros for the MAC learning forward table.
`ifndef MAC_LEARNING_FORWARD_TABLE_ASSERT_SVH
`define MAC_LEARNING_FORWARD_TABLE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define MLFT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, during reset as well.
`define MLFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mlft_pkg.sv =====
package mlft_pkg;

  localparam int unsigned MAC_W     = 48;
  localparam int unsigned PORT_W    = 8;
  localparam int unsigned GROUP_BIT = 40;

  typedef struct packed {
    logic [MAC_W-1:0]  source_mac;
    logic [MAC_W-1:0]  dest_mac;
    logic [PORT_W-1:0] ingress_port;
  } req_t;

  typedef struct packed {
    logic              flood;
    logic [PORT_W-1:0] egress_port;
  } rsp_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

// ===== hw/rtl/mlft_ram.sv =====
module mlft_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/mac_learning_forward_table.sv =====
// MAC learning forward table.
// A request (source MAC, destination MAC, ingress port on req_i) is taken at a
// rising edge where start is high and busy is low. The block then learns the
// source if it is unicast (updating the port of a matching entry, or filling
// the next free entry; nothing is learned when the table is full) and looks up
// the destination in the updated table. Group or unknown destinations flood.
// The result appears on rsp_o for exactly one cycle with done_o high; the
// receiver must take it then, it cannot stall the block.
// Timing: with F entries learned so far (F <= TABLE_ENTRIES), busy stays high
// for F + 2 cycles after the accepting edge, and done_o rises F + 2 cycles
// after that edge, in the first cycle in which a new request may be taken.
// The figure is set by the single read port of the table memory: one entry is
// read and compared against both MACs per cycle.
// Entries fill from index 0 upward and are never evicted, so a fill count
// marks the valid ones. Reset clears the fill count at once; no clearing pass.
module mac_learning_forward_table #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mlft_pkg::req_t req_i,
  output logic          done_o,
  output mlft_pkg::rsp_t rsp_o
);

  `include "mac_learning_forward_table_assert.svh"

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam int unsigned ENT_W = $bits(mlft_pkg::entry_t);

  mlft_pkg::state_e state_q, state_d;

  mlft_pkg::req_t    req_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_idx_q;
  logic              src_hit_q, src_hit_d;
  logic [IDX_W-1:0]  src_idx_q, src_idx_d;
  logic              dst_hit_q, dst_hit_d;
  logic [mlft_pkg::PORT_W-1:0] dst_port_q, dst_port_d;
  logic              done_q;
  mlft_pkg::rsp_t    rsp_q, rsp_d;

  logic              accept;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  mlft_pkg::entry_t  wr_entry;
  logic [ENT_W-1:0]  rd_raw;
  mlft_pkg::entry_t  rd_entry;
  logic              src_group;
  logic              dst_group;
  logic              has_room;

  assign accept    = start && !busy;
  assign src_group = req_q.source_mac[mlft_pkg::GROUP_BIT];
  assign dst_group = req_q.dest_mac[mlft_pkg::GROUP_BIT];
  assign has_room  = fill_q < FULL_CNT;
  assign rd_entry  = mlft_pkg::entry_t'(rd_raw);

  mlft_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .re_i   (rd_en),
    .raddr_i(cnt_q[IDX_W-1:0]),
    .rdata_o(rd_raw)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlft_pkg::ST_IDLE: begin
        if (start) begin
          state_d = mlft_pkg::ST_SCAN;
        end
      end
      mlft_pkg::ST_SCAN: begin
        // The last compare lands in the hit flags on this edge.
        if (cnt_q >= fill_q) begin
          state_d = mlft_pkg::ST_FINISH;
        end
      end
      mlft_pkg::ST_FINISH: begin
        state_d = mlft_pkg::ST_IDLE;
      end
      default: begin
        state_d = mlft_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy     = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = src_idx_q;
    wr_entry = '{mac: req_q.source_mac, port: req_q.ingress_port};
    fill_d   = fill_q;
    rsp_d    = rsp_q;
    unique case (state_q)
      mlft_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      mlft_pkg::ST_SCAN: begin
        rd_en = cnt_q < fill_q;
      end
      mlft_pkg::ST_FINISH: begin
        if (!src_group) begin
          if (src_hit_q) begin
            wr_en = 1'b1;
          end else if (has_room) begin
            wr_en   = 1'b1;
            wr_addr = fill_q[IDX_W-1:0];
            fill_d  = fill_q + CNT_W'(1);
          end
        end
        // The lookup sees the table as just updated: a destination equal to
        // the freshly learned source goes back out on the ingress port.
        if (dst_group) begin
          rsp_d = '{flood: 1'b1, egress_port: '0};
        end else if (wr_en && (req_q.dest_mac == req_q.source_mac)) begin
          rsp_d = '{flood: 1'b0, egress_port: req_q.ingress_port};
        end else if (dst_hit_q) begin
          rsp_d = '{flood: 1'b0, egress_port: dst_port_q};
        end else begin
          rsp_d = '{flood: 1'b1, egress_port: '0};
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Shared compare unit: one table entry against both MACs per cycle.
  always_comb begin
    cnt_d      = cnt_q;
    src_hit_d  = src_hit_q;
    src_idx_d  = src_idx_q;
    dst_hit_d  = dst_hit_q;
    dst_port_d = dst_port_q;
    if (accept) begin
      cnt_d     = '0;
      src_hit_d = 1'b0;
      dst_hit_d = 1'b0;
    end else begin
      if (rd_en) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (pend_q) begin
        if (!src_group && (rd_entry.mac == req_q.source_mac)) begin
          src_hit_d = 1'b1;
          src_idx_d = pend_idx_q;
        end
        if (rd_entry.mac == req_q.dest_mac) begin
          dst_hit_d  = 1'b1;
          dst_port_d = rd_entry.port;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mlft_pkg::ST_IDLE;
      fill_q    <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      src_hit_q <= 1'b0;
      dst_hit_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      pend_q    <= rd_en;
      src_hit_q <= src_hit_d;
      dst_hit_q <= dst_hit_d;
      done_q    <= state_q == mlft_pkg::ST_FINISH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    pend_idx_q <= cnt_q[IDX_W-1:0];
    src_idx_q  <= src_idx_d;
    dst_port_q <= dst_port_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `MLFT_ASSERT(a_done_after_finish, clk_i, rst_ni, done_o |-> $past(state_q == mlft_pkg::ST_FINISH), "result strobe without a finishing step")
  `MLFT_ASSERT(a_accept_goes_busy, clk_i, rst_ni, (start && !busy) |=> (busy && state_q == mlft_pkg::ST_SCAN), "accepted request did not start a scan")
  `MLFT_ASSERT(a_scan_bounded, clk_i, rst_ni, (state_q == mlft_pkg::ST_SCAN) |-> (cnt_q <= fill_q), "scan ran past the learned entries")
  `MLFT_ASSERT(a_fill_bounded, clk_i, rst_ni, fill_q <= FULL_CNT, "fill count exceeds table size")

endmodule

// ===== tb/tb_mac_learning_forward_table.sv =====
module tb_mac_learning_forward_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 600;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam logic FLOOD = 1'b1;
  localparam logic FORWARD = 1'b0;
  localparam logic FIXED = 1'b1;
  localparam logic MODELED = 1'b0;

  localparam logic [mlft_pkg::MAC_W-1:0] HOST_A = 48'h00_11_22_33_44_55;
  localparam logic [mlft_pkg::MAC_W-1:0] HOST_B = 48'h02_AB_CD_EF_01_23;
  localparam logic [mlft_pkg::MAC_W-1:0] HOST_C = 48'h00_00_00_00_00_01;
  localparam logic [mlft_pkg::MAC_W-1:0] ZERO_MAC = 48'h00_00_00_00_00_00;
  localparam logic [mlft_pkg::MAC_W-1:0] BCAST_MAC = 48'hFF_FF_FF_FF_FF_FF;
  localparam logic [mlft_pkg::MAC_W-1:0] MCAST_MAC = 48'h01_00_5E_00_00_01;
  localparam logic [mlft_pkg::MAC_W-1:0] TOP_UNICAST = 48'hFE_FF_FF_FF_FF_FF;
  localparam logic [mlft_pkg::MAC_W-1:0] GROUP_ONLY = 48'h01_00_00_00_00_00;
  localparam logic [mlft_pkg::MAC_W-1:0] STRANGER = 48'h00_DE_AD_BE_EF_00;
  localparam logic [mlft_pkg::MAC_W-1:0] STRIPE_A = 48'hAA_AA_AA_AA_AA_AA;
  localparam logic [mlft_pkg::MAC_W-1:0] STRIPE_5 = 48'h55_55_55_55_55_55;
  localparam logic [mlft_pkg::MAC_W-1:0] STRIPE_4 = 48'h54_55_55_55_55_55;

  typedef struct packed {
    mlft_pkg::req_t frame;
    logic fixed_exp;
    mlft_pkg::rsp_t want;
  } directed_row_t;

  localparam int unsigned NUM_DIRECTED = 15;

  // The table starts empty, so the first rows can be read off directly.
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{HOST_A, BCAST_MAC, 8'h03}, FIXED, '{FLOOD, 8'h00}},
    '{'{ZERO_MAC, HOST_A, 8'hFF}, FIXED, '{FORWARD, 8'h03}},
    '{'{MCAST_MAC, ZERO_MAC, 8'h10}, FIXED, '{FORWARD, 8'hFF}},
    '{'{HOST_B, MCAST_MAC, 8'h20}, FIXED, '{FLOOD, 8'h00}},
    '{'{HOST_B, HOST_B, 8'h80}, FIXED, '{FORWARD, 8'h80}},
    '{'{HOST_A, HOST_A, 8'h7F}, FIXED, '{FORWARD, 8'h7F}},
    '{'{BCAST_MAC, STRANGER, 8'h00}, FIXED, '{FLOOD, 8'h00}},
    '{'{TOP_UNICAST, TOP_UNICAST, 8'h00}, FIXED, '{FORWARD, 8'h00}},
    '{'{GROUP_ONLY, TOP_UNICAST, 8'hFF}, FIXED, '{FORWARD, 8'h00}},
    '{'{STRANGER, GROUP_ONLY, 8'h55}, FIXED, '{FLOOD, 8'h00}},
    '{'{ZERO_MAC, STRANGER, 8'hAA}, MODELED, '{FORWARD, 8'h00}},
    '{'{HOST_C, HOST_B, 8'h01}, MODELED, '{FORWARD, 8'h00}},
    '{'{TOP_UNICAST, ZERO_MAC, 8'hC3}, MODELED, '{FORWARD, 8'h00}},
    '{'{STRIPE_A, STRIPE_5, 8'hA5}, MODELED, '{FORWARD, 8'h00}},
    '{'{STRIPE_4, STRIPE_A, 8'h5A}, MODELED, '{FORWARD, 8'h00}}
  };

  logic clk_i;
  logic rst_ni;
  logic start = 1'b0;
  logic busy;
  mlft_pkg::req_t req = '0;
  logic done;
  mlft_pkg::rsp_t rsp;

  // Shadow copy of the forwarding table.
  logic shadow_valid [TABLE_DEPTH];
  logic [mlft_pkg::MAC_W-1:0] shadow_mac [TABLE_DEPTH];
  logic [mlft_pkg::PORT_W-1:0] shadow_port [TABLE_DEPTH];
  int unsigned shadow_fill;

  mlft_pkg::rsp_t expected_fwd [$];
  logic [mlft_pkg::MAC_W-1:0] seen_macs [$];
  int unsigned mismatch_count;
  longint unsigned cycle_count;

  mac_learning_forward_table #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req),
    .done_o(done),
    .rsp_o(rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int find_slot(input logic [mlft_pkg::MAC_W-1:0] mac);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (shadow_valid[i] && shadow_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // Learns the source, then looks up the destination in the updated table.
  function automatic mlft_pkg::rsp_t forward_decision(input mlft_pkg::req_t frame);
    mlft_pkg::rsp_t decision;
    int slot;
    if (!frame.source_mac[mlft_pkg::GROUP_BIT]) begin
      slot = find_slot(frame.source_mac);
      if (slot >= 0) begin
        shadow_port[slot] = frame.ingress_port;
      end else begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!shadow_valid[i]) begin
            shadow_valid[i] = 1'b1;
            shadow_mac[i] = frame.source_mac;
            shadow_port[i] = frame.ingress_port;
            shadow_fill++;
            break;
          end
        end
      end
    end
    decision.flood = FLOOD;
    decision.egress_port = '0;
    if (!frame.dest_mac[mlft_pkg::GROUP_BIT]) begin
      slot = find_slot(frame.dest_mac);
      if (slot >= 0) begin
        decision.flood = FORWARD;
        decision.egress_port = shadow_port[slot];
      end
    end
    return decision;
  endfunction

  function automatic logic [mlft_pkg::MAC_W-1:0] any_mac();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[mlft_pkg::MAC_W-1:0];
  endfunction

  // Mostly known stations so that updates and hits are frequent; fresh
  // unicast sources keep filling the table until it is full.
  function automatic mlft_pkg::req_t random_frame();
    mlft_pkg::req_t frame;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45 && seen_macs.size() != 0) begin
      frame.source_mac = seen_macs[$urandom_range(seen_macs.size() - 1)];
    end else if (pick < 80) begin
      frame.source_mac = any_mac();
      frame.source_mac[mlft_pkg::GROUP_BIT] = 1'b0;
      seen_macs.push_back(frame.source_mac);
    end else if (pick < 90) begin
      frame.source_mac = any_mac();
    end else begin
      frame.source_mac = any_mac();
      frame.source_mac[mlft_pkg::GROUP_BIT] = 1'b1;
    end
    pick = $urandom_range(99);
    if (pick < 50 && seen_macs.size() != 0) begin
      frame.dest_mac = seen_macs[$urandom_range(seen_macs.size() - 1)];
    end else if (pick < 65) begin
      frame.dest_mac = frame.source_mac;
    end else if (pick < 80) begin
      frame.dest_mac = any_mac();
    end else if (pick < 88) begin
      frame.dest_mac = BCAST_MAC;
    end else begin
      frame.dest_mac = any_mac();
      frame.dest_mac[mlft_pkg::GROUP_BIT] = 1'b1;
    end
    frame.ingress_port = mlft_pkg::PORT_W'($urandom_range(255));
    return frame;
  endfunction

  // The gap length spans the whole search, so it can end at any point of it.
  task automatic sender_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, shadow_fill + 3)) @(posedge clk_i);
    end
  endtask

  task automatic issue(input mlft_pkg::req_t frame, input logic fixed_exp,
                       input mlft_pkg::rsp_t want);
    mlft_pkg::rsp_t predicted;
    start <= 1'b1;
    req <= frame;
    do @(posedge clk_i); while (busy);
    predicted = forward_decision(frame);
    expected_fwd.push_back(fixed_exp ? want : predicted);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_fwd.size() != 0);
  endtask

  always @(posedge clk_i) begin : check_results
    mlft_pkg::rsp_t want;
    if (rst_ni && done) begin
      if (expected_fwd.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("unexpected result: flood=%0b egress_port=%0d", rsp.flood,
                   rsp.egress_port);
        end
        mismatch_count++;
      end else begin
        want = expected_fwd.pop_front();
        if (rsp.flood !== want.flood || rsp.egress_port !== want.egress_port) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display({"result mismatch: expected flood=%0b egress_port=%0d, ",
                      "got flood=%0b egress_port=%0d"},
                     want.flood, want.egress_port, rsp.flood, rsp.egress_port);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned idle_pct [3];
    idle_pct = '{9, 53, 0};
    mismatch_count = 0;
    cycle_count = 0;
    shadow_fill = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_mac[i] = '0;
      shadow_port[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      sender_gap(idle_pct[0]);
      issue(DIRECTED[i].frame, DIRECTED[i].fixed_exp, DIRECTED[i].want);
    end

    // Each phase starts with the block idle and no request outstanding.
    for (int p = 0; p < 3; p++) begin
      drain();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sender_gap(idle_pct[p]);
        issue(random_frame(), MODELED, '0);
      end
    end

    drain();
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
